// File: rtl/tlbfat_pkg.sv
// Shared constants and types for the TLB address translator.
`default_nettype none

package tlbfat_pkg;

    // Page offset width and the fixed bias between page and frame numbers
    localparam int OFFSET_BITS = 12;
    localparam int FRAME_BIAS  = 4;

    // Configuration register
    localparam int CFG_W       = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Event counters
    localparam int CNT_W   = 32;
    localparam int NUM_CNT = 5;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        CNT_TLB_HIT    = 3'd0,
        CNT_TLB_MISS   = 3'd1,
        CNT_TABLE_HIT  = 3'd2,
        CNT_TABLE_MISS = 3'd3,
        CNT_ACCESS     = 3'd4
    } cnt_sel_t;

    // Saturating increment
    function automatic cnt_t cnt_bump(input cnt_t value, input logic en);
        cnt_t result;
        result = value;
        if (en && (value != {CNT_W{1'b1}}))
        begin
            result = value + cnt_t'(1);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tlbfat_if.sv
// Request and result channel interfaces of the TLB address translator.
`default_nettype none

interface tlbfat_req_if #(
    parameter int PAGE_BITS = 8
);
    import tlbfat_pkg::*;

    logic                             valid;
    logic                             ready;
    logic [PAGE_BITS+OFFSET_BITS-1:0] vaddr;

    modport source (output valid, output vaddr, input ready);
    modport sink   (input valid, input vaddr, output ready);
endinterface

interface tlbfat_rsp_if #(
    parameter int PAGE_BITS = 8
);
    import tlbfat_pkg::*;

    logic                               valid;
    logic                               ready;
    logic [PAGE_BITS+OFFSET_BITS:0]     paddr;
    logic                               tlb_hit;
    logic                               page_fault;
    cnt_t                               tlb_hit_count;
    cnt_t                               tlb_miss_count;
    cnt_t                               table_hit_count;
    cnt_t                               table_miss_count;
    cnt_t                               access_count;

    modport source (
        output valid, output paddr, output tlb_hit, output page_fault,
        output tlb_hit_count, output tlb_miss_count, output table_hit_count,
        output table_miss_count, output access_count, input ready
    );
    modport sink (
        input valid, input paddr, input tlb_hit, input page_fault,
        input tlb_hit_count, input tlb_miss_count, input table_hit_count,
        input table_miss_count, input access_count, output ready
    );
endinterface

`default_nettype wire

// File: rtl/tlb_fifo_address_translator.sv
// Top level: fully associative TLB with FIFO replacement and page table fallback.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------------------------
//  req     | in  | valid / ready    | vaddr
//  rsp     | out | valid / ready    | paddr, tlb_hit, page_fault, counters
//  cfg     | in  | cfg_write_en     | cfg_write_data = tlb_entries_in_use
//
//  One request a cycle while the result is not stalled. A request waits in the input register, where the
//  parallel tag compare, the page table valid lookup and all state updates happen;
//  its result is then registered in the output register, which holds it until taken.
//  Reset empties the TLB and the page table and clears the counters; no clearing pass.
//  A stalled result holds the input register; req.ready stays high while it is empty.
`default_nettype none

module tlb_fifo_address_translator #(
    parameter int TLB_DEPTH = 16,
    parameter int PAGE_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    tlbfat_req_if.sink                         req,
    tlbfat_rsp_if.source                       rsp,
    input  wire logic                          cfg_write_en,
    input  wire logic [tlbfat_pkg::CFG_W-1:0]  cfg_write_data
);
    import tlbfat_pkg::*;

    localparam int VA_W    = PAGE_BITS + OFFSET_BITS;
    localparam int FRAME_W = PAGE_BITS + 1;
    localparam int PA_W    = FRAME_W + OFFSET_BITS;
    localparam int PAGES   = 1 << PAGE_BITS;
    localparam int FILL_W  = $clog2(TLB_DEPTH + 1);
    localparam int PTR_W   = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int SUM_W   = FILL_W + 1;
    localparam int CMP_W   = 8;

    typedef logic [PAGE_BITS-1:0] page_t;

    // Configuration
    logic [CFG_W-1:0]     cfg_reg;

    // Input register
    logic                 in_valid_reg;
    logic [VA_W-1:0]      va_reg;

    // TLB ring
    page_t                tag_reg [TLB_DEPTH];
    logic [TLB_DEPTH-1:0] tlb_valid_reg;
    logic [TLB_DEPTH-1:0] tlb_valid_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [PTR_W-1:0]     oldest_reg;
    logic [PTR_W-1:0]     oldest_next;

    // Page table: each mapped page sits at frame page + bias, so only validity is kept
    logic [PAGES-1:0]     table_valid_reg;
    logic [PAGES-1:0]     table_valid_next;

    cnt_t                 cnt_reg  [NUM_CNT];
    cnt_t                 cnt_next [NUM_CNT];

    // Output register
    logic                 out_valid_reg;
    logic [PA_W-1:0]      pa_reg;
    logic                 hit_reg;
    logic                 fault_reg;

    logic                 advance;
    logic                 process;
    page_t                page;
    logic [OFFSET_BITS-1:0] offset;
    logic [TLB_DEPTH-1:0] match;
    logic                 hit;
    logic                 table_hit;
    logic                 fault;
    logic [FRAME_W-1:0]   frame;
    logic [CMP_W-1:0]     cap;
    logic                 evict;
    logic [SUM_W-1:0]     slot_sum;
    logic [PTR_W-1:0]     slot;

    assign advance   = !out_valid_reg || rsp.ready;
    assign process   = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign page   = va_reg[VA_W-1:OFFSET_BITS];
    assign offset = va_reg[OFFSET_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < TLB_DEPTH; i++)
        begin
            match[i] = tlb_valid_reg[i] && (tag_reg[i] == page);
        end
    end

    assign hit       = |match;
    assign table_hit = !hit && table_valid_reg[page];
    assign fault     = !hit && !table_valid_reg[page];
    assign frame     = {1'b0, page} + FRAME_W'(FRAME_BIAS);

    // Clamp the in-use count to 1..TLB_DEPTH
    always_comb
    begin
        cap = CMP_W'(cfg_reg);
        if (cfg_reg == '0)
        begin
            cap = CMP_W'(1);
        end
        else if (CMP_W'(cfg_reg) > CMP_W'(TLB_DEPTH))
        begin
            cap = CMP_W'(TLB_DEPTH);
        end
    end

    assign evict    = CMP_W'(fill_reg) >= cap;
    assign slot_sum = SUM_W'(oldest_reg) + SUM_W'(fill_reg);

    always_comb
    begin
        if (slot_sum >= SUM_W'(TLB_DEPTH))
        begin
            slot = PTR_W'(slot_sum - SUM_W'(TLB_DEPTH));
        end
        else
        begin
            slot = PTR_W'(slot_sum);
        end
    end

    always_comb
    begin
        tlb_valid_next   = tlb_valid_reg;
        fill_next        = fill_reg;
        oldest_next      = oldest_reg;
        table_valid_next = table_valid_reg;
        for (int k = 0; k < NUM_CNT; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end
        if (process)
        begin
            cnt_next[CNT_ACCESS]     = cnt_bump(cnt_reg[CNT_ACCESS], 1'b1);
            cnt_next[CNT_TLB_HIT]    = cnt_bump(cnt_reg[CNT_TLB_HIT], hit);
            cnt_next[CNT_TLB_MISS]   = cnt_bump(cnt_reg[CNT_TLB_MISS], !hit);
            cnt_next[CNT_TABLE_HIT]  = cnt_bump(cnt_reg[CNT_TABLE_HIT], table_hit);
            cnt_next[CNT_TABLE_MISS] = cnt_bump(cnt_reg[CNT_TABLE_MISS], fault);
            if (fault)
            begin
                table_valid_next[page] = 1'b1;
            end
            if (!hit)
            begin
                // Drop the oldest entry once the fill count reaches the in-use count; the new one lands after the last
                if (evict)
                begin
                    tlb_valid_next[oldest_reg] = 1'b0;
                    if (oldest_reg == PTR_W'(TLB_DEPTH - 1))
                    begin
                        oldest_next = '0;
                    end
                    else
                    begin
                        oldest_next = oldest_reg + PTR_W'(1);
                    end
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                tlb_valid_next[slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg         <= CFG_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            tlb_valid_reg   <= '0;
            fill_reg        <= '0;
            oldest_reg      <= '0;
            table_valid_reg <= '0;
            for (int k = 0; k < NUM_CNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                cfg_reg <= cfg_write_data;
            end
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            tlb_valid_reg   <= tlb_valid_next;
            fill_reg        <= fill_next;
            oldest_reg      <= oldest_next;
            table_valid_reg <= table_valid_next;
            for (int k = 0; k < NUM_CNT; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            va_reg <= req.vaddr;
        end
        if (process && !hit)
        begin
            tag_reg[slot] <= page;
        end
        if (process)
        begin
            pa_reg    <= {frame, offset};
            hit_reg   <= hit;
            fault_reg <= fault;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.paddr            = pa_reg;
    assign rsp.tlb_hit          = hit_reg;
    assign rsp.page_fault       = fault_reg;
    assign rsp.tlb_hit_count    = cnt_reg[CNT_TLB_HIT];
    assign rsp.tlb_miss_count   = cnt_reg[CNT_TLB_MISS];
    assign rsp.table_hit_count  = cnt_reg[CNT_TABLE_HIT];
    assign rsp.table_miss_count = cnt_reg[CNT_TABLE_MISS];
    assign rsp.access_count     = cnt_reg[CNT_ACCESS];

    // Fill count tracks the ring's valid bits
    a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tlb_valid_reg) == int'(fill_reg))
        else $error("TLB fill count disagrees with valid entries");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= TLB_DEPTH)
        else $error("TLB fill count above depth");

    a_hit_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && fault_reg))
        else $error("TLB hit and page fault on the same result");

    // A fault maps the page, so the same page cannot fault on the next request
    a_no_repeat_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (process && fault) |=> !(in_valid_reg && fault && (page == $past(page))))
        else $error("Page faulted twice in a row");

    // Until saturation, hits and misses add up to the accesses
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (cnt_reg[CNT_ACCESS] != {CNT_W{1'b1}})) |->
        ((33'(cnt_reg[CNT_TLB_HIT]) + 33'(cnt_reg[CNT_TLB_MISS]))
            == 33'(cnt_reg[CNT_ACCESS])))
        else $error("Hit and miss counts do not sum to access count");

endmodule

`default_nettype wire
